// ===== src/ple_pkg.sv =====
// shared types and codes for the positional list engine
package ple_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_LOCATE = 2'd2;
	localparam logic [1:0] CMD_GET    = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_POS   = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [6:0]         position;
		logic signed [31:0] value;
	} ple_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic [5:0]         found_at;
		logic [6:0]         count;
	} ple_out_t;

endpackage

// ===== src/positional_list_engine_core.sv =====
// ordered list of words in a single-port-read store with a shift sequencer
//
//  channel   signals            handshake
//  command   start, req, busy   word taken when start is high and busy is low
//  result    done, rsp          word valid for one cycle while done is high
//
// a rejected command or a locate on an empty list is answered without a walk;
// get reads one entry, delete and insert walk the entries from the position to
// the list end, and locate walks from the head to the first match or the end.
// shifts and searches walk one entry per cycle through the registered read port.
// reset clears state, length, walk count and flags; entries are written before read.
// done pulses once and busy drops in that cycle: the receiver cannot stall.
module positional_list_engine_core
	import ple_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ple_in_t  req,
	output logic     busy,
	output logic     done,
	output ple_out_t rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > 7) ? LW : 7;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_DEL  = 3'd2;
	localparam logic [2:0] S_LOC  = 3'd3;
	localparam logic [2:0] S_GET  = 3'd4;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rdata_s1;
	logic          rv_s1;
	logic [IW-1:0] ra_s1;

	logic [2:0]    state_q, state_d;
	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] rem_q, rem_d;
	logic [IW-1:0] rd_ptr_q, rd_ptr_d;
	logic [6:0]    pos_q, pos_d;
	logic [31:0]   val_q, val_d;
	logic [31:0]   data_q, data_d;
	logic          done_q, done_d;
	ple_out_t      rsp_q, rsp_d;

	logic          rd_en;
	logic          we;
	logic [IW-1:0] wa;
	logic [31:0]   wd;
	logic [CW-1:0] pos_ext, len_ext;

	assign pos_ext = CW'(req.position);
	assign len_ext = CW'(len_q);
	assign rd_en   = (state_q != S_IDLE) && (rem_q != '0);

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		rem_d    = rem_q;
		rd_ptr_d = rd_ptr_q;
		pos_d    = pos_q;
		val_d    = val_q;
		data_d   = data_q;
		done_d   = 1'b0;
		rsp_d    = rsp_q;
		we       = 1'b0;
		wa       = ra_s1;
		wd       = rdata_s1;

		// read issue: insert walks down, everything else walks up
		if (rd_en) begin
			rem_d    = rem_q - LW'(1);
			rd_ptr_d = (state_q == S_INS) ? rd_ptr_q - IW'(1) : rd_ptr_q + IW'(1);
		end

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					pos_d           = req.position;
					val_d           = req.value;
					rsp_d.status    = ST_OK;
					rsp_d.data      = '0;
					rsp_d.found_at  = '0;
					rsp_d.count     = 7'(len_q);
					unique case (req.cmd)
						CMD_INSERT: begin
							if (pos_ext > len_ext) begin
								rsp_d.status = ST_BAD_POS;
								done_d       = 1'b1;
							end else if (len_q == LW'(CAPACITY)) begin
								rsp_d.status = ST_FULL;
								done_d       = 1'b1;
							end else begin
								state_d  = S_INS;
								rd_ptr_d = IW'(len_q - LW'(1));
								rem_d    = LW'(len_ext - pos_ext);
							end
						end
						CMD_DELETE: begin
							if (pos_ext >= len_ext) begin
								rsp_d.status = ST_BAD_POS;
								done_d       = 1'b1;
							end else begin
								state_d  = S_DEL;
								rd_ptr_d = IW'(req.position);
								rem_d    = LW'(len_ext - pos_ext);
							end
						end
						CMD_LOCATE: begin
							if (len_q == '0) begin
								rsp_d.status = ST_NOT_FOUND;
								done_d       = 1'b1;
							end else begin
								state_d  = S_LOC;
								rd_ptr_d = '0;
								rem_d    = len_q;
							end
						end
						CMD_GET: begin
							if (pos_ext >= len_ext) begin
								rsp_d.status = ST_BAD_POS;
								done_d       = 1'b1;
							end else begin
								state_d  = S_GET;
								rd_ptr_d = IW'(req.position);
								rem_d    = LW'(1);
							end
						end
						default: ;
					endcase
				end
			end
			S_INS: begin
				if (rv_s1) begin
					we = 1'b1;
					wa = ra_s1 + IW'(1);
				end else if (rem_q == '0) begin
					// hole is open at the position, drop the new word in
					we          = 1'b1;
					wa          = IW'(pos_q);
					wd          = val_q;
					len_d       = len_q + LW'(1);
					rsp_d.count = 7'(len_q + LW'(1));
					done_d      = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_DEL: begin
				if (rv_s1) begin
					if (ra_s1 == IW'(pos_q)) begin
						data_d = rdata_s1;
					end else begin
						we = 1'b1;
						wa = ra_s1 - IW'(1);
					end
				end else if (rem_q == '0) begin
					len_d       = len_q - LW'(1);
					rsp_d.data  = data_q;
					rsp_d.count = 7'(len_q - LW'(1));
					done_d      = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_LOC: begin
				if (rv_s1 && (rdata_s1 == val_q)) begin
					rsp_d.found_at = 6'(ra_s1);
					done_d         = 1'b1;
					state_d        = S_IDLE;
				end else if (!rv_s1 && (rem_q == '0)) begin
					rsp_d.status = ST_NOT_FOUND;
					done_d       = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_GET: begin
				if (rv_s1) begin
					rsp_d.data = rdata_s1;
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			rem_q   <= '0;
			rv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			rv_s1   <= rd_en;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_ptr_q <= rd_ptr_d;
		ra_s1    <= rd_ptr_q;
		pos_q    <= pos_d;
		val_q    <= val_d;
		data_q   <= data_d;
		rsp_q    <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== tb/ple_checker.sv =====
// checker for the positional list engine: predicts every command and compares each result
`timescale 1ns / 1ps

module ple_checker
	import ple_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  ple_in_t  req,
	input  logic     done,
	input  ple_out_t rsp,
	output int       errors,
	output int       pending,
	output int       checked
);

	// predicted list contents and length
	logic signed [31:0] entry_mem [CAPACITY];
	int                 list_len;

	ple_out_t predicted_rsp_q [$];
	ple_out_t want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("%0t: mismatch on %s: got %0h, expected %0h (result %0d)",
			$realtime, what, got, exp_val, checked);
		errors++;
	endtask

	function automatic ple_out_t apply_list_cmd(input ple_in_t c);
		ple_out_t r;
		int       k;
		r = '0;
		r.status = ST_OK;
		case (c.cmd)
			CMD_INSERT: begin
				if (c.position > list_len) begin
					r.status = ST_BAD_POS;
				end else if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (k = list_len; k > c.position; k--)
						entry_mem[k] = entry_mem[k - 1];
					entry_mem[c.position] = c.value;
					list_len++;
				end
			end
			CMD_DELETE: begin
				if (c.position >= list_len) begin
					r.status = ST_BAD_POS;
				end else begin
					r.data = entry_mem[c.position];
					for (k = c.position + 1; k < list_len; k++)
						entry_mem[k - 1] = entry_mem[k];
					list_len--;
				end
			end
			CMD_LOCATE: begin
				// first match wins
				r.status = ST_NOT_FOUND;
				for (k = 0; k < list_len; k++) begin
					if (r.status == ST_NOT_FOUND && entry_mem[k] == c.value) begin
						r.status   = ST_OK;
						r.found_at = k[5:0];
					end
				end
			end
			default: begin
				if (c.position >= list_len)
					r.status = ST_BAD_POS;
				else
					r.data = entry_mem[c.position];
			end
		endcase
		r.count = list_len[6:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			predicted_rsp_q.delete();
			pending = 0;
		end else begin
			// result first: a new command may be taken in the same cycle
			if (done) begin
				if (predicted_rsp_q.size() == 0) begin
					report_mismatch("result with no command outstanding",
						{30'd0, rsp.status}, '0);
				end else begin
					want = predicted_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", {30'd0, rsp.status}, {30'd0, want.status});
					if (rsp.data !== want.data)
						report_mismatch("data", rsp.data, want.data);
					if (rsp.found_at !== want.found_at)
						report_mismatch("found_at", {26'd0, rsp.found_at},
							{26'd0, want.found_at});
					if (rsp.count !== want.count)
						report_mismatch("count", {25'd0, rsp.count}, {25'd0, want.count});
				end
				checked++;
			end
			if (start && !busy)
				predicted_rsp_q.push_back(apply_list_cmd(req));
			pending = predicted_rsp_q.size();
		end
	end

endmodule

// ===== tb/positional_list_engine_core_test.sv =====
// stimulus and verdict for the positional list engine testbench
`timescale 1ns / 1ps

module positional_list_engine_core_test;
	import ple_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int N_RANDOM    = 700;
	localparam int CYCLE_LIMIT = 400000;

	localparam int PH_GROW   = 0;
	localparam int PH_SHRINK = 1;
	localparam int PH_MIXED  = 2;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	ple_in_t  req    = '0;
	logic     busy;
	logic     done;
	ple_out_t rsp;

	int errors;
	int pending;
	int checked;
	int cycles;

	// length as the stimulus sees it, used to aim positions
	int shadow_len;
	int cmd_seen [4];
	int full_hits;
	int empty_hits;

	logic signed [31:0] value_pool [8] = '{32'sd0, -32'sd1, 32'sd1, 32'h80000000,
		32'h7fffffff, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'sd42};

	positional_list_engine_core #(.CAPACITY(CAPACITY)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	ple_checker #(.CAPACITY(CAPACITY)) i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic ple_in_t mk(input logic [1:0] c, input int pos,
			input logic signed [31:0] v);
		ple_in_t w;
		w.cmd      = c;
		w.position = pos[6:0];
		w.value    = v;
		return w;
	endfunction

	function automatic ple_in_t pick_cmd(input int phase);
		ple_in_t w;
		int      r;
		int      ins_w;
		int      del_w;
		r = $urandom_range(0, 99);
		case (phase)
			PH_GROW:   begin ins_w = 70; del_w = 10; end
			PH_SHRINK: begin ins_w = 10; del_w = 70; end
			default:   begin ins_w = 30; del_w = 30; end
		endcase
		if (r < ins_w)
			w.cmd = CMD_INSERT;
		else if (r < ins_w + del_w)
			w.cmd = CMD_DELETE;
		else if (r < ins_w + del_w + (100 - ins_w - del_w) / 2)
			w.cmd = CMD_LOCATE;
		else
			w.cmd = CMD_GET;
		// mostly valid positions, now and then anything in range
		if ($urandom_range(0, 9) == 0 || w.cmd == CMD_LOCATE)
			w.position = 7'($urandom_range(0, CAPACITY));
		else if (w.cmd == CMD_INSERT)
			w.position = 7'($urandom_range(0, shadow_len));
		else
			w.position = (shadow_len > 0) ? 7'($urandom_range(0, shadow_len - 1)) : 7'd0;
		// a small pool of words makes locate hit and gives duplicates
		if ($urandom_range(0, 1) == 0)
			w.value = value_pool[$urandom_range(0, 7)];
		else
			w.value = $urandom;
		return w;
	endfunction

	task automatic send_word(input ple_in_t w, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= w;
		do @(posedge clk); while (busy);
		cmd_seen[w.cmd]++;
		if (w.cmd == CMD_INSERT && w.position <= shadow_len) begin
			if (shadow_len >= CAPACITY)
				full_hits++;
			else
				shadow_len++;
		end else if (w.cmd == CMD_DELETE && w.position < shadow_len) begin
			shadow_len--;
			if (shadow_len == 0)
				empty_hits++;
		end
	endtask

	function automatic int pick_gap(input int n);
		// every third stretch runs back to back
		if ((n / 37) % 3 == 1)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	initial begin
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, ends of the list, extreme words, duplicates
		send_word(mk(CMD_GET,    0,  32'sd0), pick_gap(0));
		send_word(mk(CMD_DELETE, 0,  32'sd0), pick_gap(0));
		send_word(mk(CMD_LOCATE, 0,  32'sd0), pick_gap(0));
		send_word(mk(CMD_INSERT, 1,  32'sd7), pick_gap(0));
		send_word(mk(CMD_INSERT, 0,  32'h80000000), pick_gap(0));
		send_word(mk(CMD_INSERT, 1,  32'h7fffffff), pick_gap(0));
		send_word(mk(CMD_INSERT, 0,  -32'sd1), pick_gap(0));
		send_word(mk(CMD_INSERT, 3,  32'sd0), pick_gap(0));
		send_word(mk(CMD_INSERT, 64, 32'sd5), pick_gap(0));
		send_word(mk(CMD_INSERT, 2,  -32'sd1), pick_gap(0));
		send_word(mk(CMD_LOCATE, 0,  -32'sd1), pick_gap(0));
		send_word(mk(CMD_LOCATE, 0,  32'h7fffffff), pick_gap(0));
		send_word(mk(CMD_LOCATE, 64, 32'sd12345), pick_gap(0));
		send_word(mk(CMD_GET,    4,  32'sd0), pick_gap(0));
		send_word(mk(CMD_GET,    5,  32'sd0), pick_gap(0));
		send_word(mk(CMD_GET,    64, 32'sd0), pick_gap(0));
		send_word(mk(CMD_DELETE, 5,  32'sd0), pick_gap(0));
		send_word(mk(CMD_DELETE, 0,  32'sd0), pick_gap(0));
		send_word(mk(CMD_DELETE, 3,  32'sd0), pick_gap(0));
		send_word(mk(CMD_DELETE, 64, 32'sd0), pick_gap(0));
		send_word(mk(CMD_GET,    0,  32'sd0), pick_gap(0));

		// random: grow to full, churn, drain to empty, repeat
		for (int n = 0; n < N_RANDOM; n++) begin
			case (n / 100)
				0, 3, 4: phase = PH_GROW;
				2, 6:    phase = PH_SHRINK;
				default: phase = PH_MIXED;
			endcase
			send_word(pick_cmd(phase), pick_gap(n));
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("sent %0d commands: %0d insert, %0d delete, %0d locate, %0d get",
			cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
			cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE], cmd_seen[CMD_LOCATE],
			cmd_seen[CMD_GET]);
		$display("%0d results checked, inserts into a full list %0d, list drained %0d times",
			checked, full_hits, empty_hits);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== positional_list_engine_core.f =====
src/ple_pkg.sv
src/positional_list_engine_core.sv
tb/ple_checker.sv
tb/positional_list_engine_core_test.sv
